@@ rtl/pfa_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pfa_pkg: shared definitions for the page frame allocator
// Field widths, operation and status codes, and parameter defaults.
// ---------------------------------------------------------------------------
package pfa_pkg;

  localparam int MAX_FRAMES_DEF = 1024;
  localparam int MAX_RUN_DEF    = 64;

  localparam int OP_W     = 2;
  localparam int RUN_W    = 7;
  localparam int FRAME_W  = 10;
  localparam int STATUS_W = 2;
  localparam int REF_W    = 8;
  localparam int USABLE_W = 11;

  localparam logic [OP_W-1:0] OP_ALLOC_CONTIG = 2'd0;
  localparam logic [OP_W-1:0] OP_ALLOC_SCATTER = 2'd1;
  localparam logic [OP_W-1:0] OP_FREE         = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK           = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_FREE      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ALREADY_FREE = 2'd2;

  localparam int REG_USABLE_FRAMES = 0;

endpackage

@@ rtl/page_frame_allocator_unit.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// page_frame_allocator_unit: reference-counted page frame allocator
// Free list in block RAM, first-fit contiguous scan, list pops and frees.
// ---------------------------------------------------------------------------
// One request is in flight at a time; in_stall stays high until its last
// result transfer has been loaded into the output register. After reset a
// clearing pass builds the ascending free list and zeroes all counts; no
// request is taken during it (configuration is).
// Work per request: a contiguous allocation scans one frame per cycle from
// frame 0, over up to min(usable_frames, MAX_FRAMES) frames, then unlinks
// each frame of the run in three steps (one read, two writes on the link
// memories' single write ports) and posts the result. A discontiguous
// allocation pops frames from the list head through the same steps and
// posts each one as its own result, waiting while the output is stalled.
// The worst case is set by the scan over the count memory.
// ---------------------------------------------------------------------------
module page_frame_allocator_unit #(
  parameter int MAX_FRAMES = pfa_pkg::MAX_FRAMES_DEF,
  parameter int MAX_RUN    = pfa_pkg::MAX_RUN_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // request channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [pfa_pkg::OP_W-1:0]      op,
  input  logic [pfa_pkg::RUN_W-1:0]     run_length,
  input  logic [pfa_pkg::FRAME_W-1:0]   frame,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [pfa_pkg::FRAME_W-1:0]   frame_out,
  output logic [pfa_pkg::STATUS_W-1:0]  status,
  output logic                          last,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import pfa_pkg::*;

  localparam int FW = $clog2(MAX_FRAMES);   // frame index width
  localparam int LW = FW + 1;               // link width, room for the null link
  localparam int BW = (LW > USABLE_W) ? LW : USABLE_W;
  localparam logic [LW-1:0] NULL_LINK = LW'(MAX_FRAMES);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_SCAN, S_UNL_RD, S_UNL_W1, S_UNL_W2,
    S_FR_RD, S_FR_CHK, S_FR_P1, S_FR_P2, S_EMIT
  } state_t;

  state_t state;

  // storage
  logic [REF_W-1:0] cnt_mem [MAX_FRAMES];
  logic [LW-1:0]    nxt_mem [MAX_FRAMES];
  logic [LW-1:0]    prv_mem [MAX_FRAMES];

  logic [REF_W-1:0] cnt_rd;
  logic [LW-1:0]    nxt_rd, prv_rd;

  // memory ports
  logic             cnt_we, nxt_we, prv_we;
  logic [FW-1:0]    cnt_ra, cnt_wa, nxt_wa, prv_wa;
  logic [REF_W-1:0] cnt_wd;
  logic [LW-1:0]    nxt_wd, prv_wd;

  // control registers
  logic [USABLE_W-1:0] usable_frames;
  logic [LW-1:0]       list_head;
  logic [LW-1:0]       free_total;
  logic [FW-1:0]       clr_idx;
  logic [OP_W-1:0]     op_r;
  logic [FRAME_W-1:0]  frm_r;
  logic [RUN_W-1:0]    n_r;
  logic [RUN_W-1:0]    rem;
  logic [RUN_W-1:0]    len;
  logic [FW-1:0]       cur;
  logic [FW-1:0]       start;
  logic [BW-1:0]       iss;
  logic                chk;
  logic [FW-1:0]       chk_idx;
  logic [FRAME_W-1:0]  em_frame;
  logic [STATUS_W-1:0] em_status;
  logic                em_last;
  logic                em_more;

  // derived
  logic [RUN_W-1:0] n_in;
  logic [BW-1:0]    bound;
  logic             in_fire, out_fire, cfg_wr, slot_free;
  logic [FW-1:0]    head_idx;

  always_comb begin
    if (run_length == '0) begin
      n_in = RUN_W'(1);
    end else if (32'(run_length) > MAX_RUN) begin
      n_in = RUN_W'(MAX_RUN);
    end else begin
      n_in = run_length;
    end
  end

  assign bound = (32'(usable_frames) > MAX_FRAMES) ? BW'(MAX_FRAMES) : BW'(usable_frames);

  assign in_stall  = (state != S_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign out_fire  = out_valid && !out_stall;
  assign slot_free = !out_valid || !out_stall;
  assign head_idx  = list_head[FW-1:0];

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'(REG_USABLE_FRAMES));
  assign prdata = (paddr[2] == 1'(REG_USABLE_FRAMES)) ? 32'(usable_frames) : 32'd0;

  // memory port steering
  always_comb begin
    cnt_we = 1'b0;  cnt_wa = cur;  cnt_wd = '0;
    nxt_we = 1'b0;  nxt_wa = cur;  nxt_wd = NULL_LINK;
    prv_we = 1'b0;  prv_wa = cur;  prv_wd = NULL_LINK;
    cnt_ra = cur;
    case (state)
      S_CLR: begin
        cnt_we = 1'b1;  cnt_wa = clr_idx;  cnt_wd = '0;
        nxt_we = 1'b1;  nxt_wa = clr_idx;  nxt_wd = {1'b0, clr_idx} + LW'(1);
        prv_we = 1'b1;  prv_wa = clr_idx;
        prv_wd = (clr_idx == '0) ? NULL_LINK : ({1'b0, clr_idx} - LW'(1));
      end
      S_SCAN: begin
        cnt_ra = iss[FW-1:0];
      end
      S_UNL_W1: begin
        // bridge the neighbors over the frame being taken
        cnt_we = 1'b1;  cnt_wd = REF_W'(1);
        nxt_we = (prv_rd != NULL_LINK);  nxt_wa = prv_rd[FW-1:0];  nxt_wd = nxt_rd;
        prv_we = (nxt_rd != NULL_LINK);  prv_wa = nxt_rd[FW-1:0];  prv_wd = prv_rd;
      end
      S_UNL_W2: begin
        nxt_we = 1'b1;
        prv_we = 1'b1;
      end
      S_FR_CHK: begin
        cnt_we = (cnt_rd != '0);
        cnt_wd = cnt_rd - REF_W'(1);
      end
      S_FR_P1: begin
        prv_we = 1'b1;
        nxt_we = 1'b1;  nxt_wd = list_head;
      end
      S_FR_P2: begin
        prv_we = 1'b1;  prv_wa = head_idx;  prv_wd = {1'b0, cur};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_wa] <= cnt_wd;
    end
    cnt_rd <= cnt_mem[cnt_ra];
  end

  always_ff @(posedge clk) begin
    if (nxt_we) begin
      nxt_mem[nxt_wa] <= nxt_wd;
    end
    nxt_rd <= nxt_mem[cur];
  end

  always_ff @(posedge clk) begin
    if (prv_we) begin
      prv_mem[prv_wa] <= prv_wd;
    end
    prv_rd <= prv_mem[cur];
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLR;
      clr_idx       <= '0;
      usable_frames <= USABLE_W'(MAX_FRAMES);
      list_head     <= '0;
      free_total    <= LW'(MAX_FRAMES);
      out_valid     <= 1'b0;
      chk           <= 1'b0;
    end else begin
      if (cfg_wr) begin
        usable_frames <= pwdata[USABLE_W-1:0];
      end
      // drop the result once taken; EMIT may load a new one below
      if (out_fire) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_CLR: begin
          clr_idx <= clr_idx + FW'(1);
          if (clr_idx == FW'(MAX_FRAMES - 1)) begin
            state <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (in_fire) begin
            op_r  <= op;
            frm_r <= frame;
            n_r   <= n_in;
            case (op)
              OP_ALLOC_CONTIG: begin
                iss   <= '0;
                chk   <= 1'b0;
                len   <= '0;
                state <= S_SCAN;
              end
              OP_ALLOC_SCATTER: begin
                if (32'(free_total) < 32'(n_in)) begin
                  em_frame <= '0;  em_status <= ST_NO_FREE;
                  em_last  <= 1'b1;  em_more <= 1'b0;
                  state    <= S_EMIT;
                end else begin
                  cur   <= head_idx;
                  rem   <= n_in;
                  state <= S_UNL_RD;
                end
              end
              OP_FREE: begin
                if (32'(frame) >= MAX_FRAMES) begin
                  em_frame <= frame;  em_status <= ST_ALREADY_FREE;
                  em_last  <= 1'b1;   em_more   <= 1'b0;
                  state    <= S_EMIT;
                end else begin
                  cur   <= FW'(frame);
                  state <= S_FR_RD;
                end
              end
              default: begin
                state <= S_IDLE;  // unused op: no result
              end
            endcase
          end
        end

        S_SCAN: begin
          // cnt_rd holds the count of chk_idx when chk is set
          if (chk && (cnt_rd == '0) && (len + RUN_W'(1) == n_r)) begin
            cur   <= (len == '0) ? chk_idx : start;
            start <= (len == '0) ? chk_idx : start;
            rem   <= n_r;
            state <= S_UNL_RD;
          end else begin
            if (chk) begin
              if (cnt_rd == '0) begin
                if (len == '0) begin
                  start <= chk_idx;
                end
                len <= len + RUN_W'(1);
              end else begin
                len <= '0;
              end
            end
            if (iss < bound) begin
              chk     <= 1'b1;
              chk_idx <= iss[FW-1:0];
              iss     <= iss + BW'(1);
            end else begin
              chk <= 1'b0;
              if (!chk) begin
                em_frame <= '0;  em_status <= ST_NO_FREE;
                em_last  <= 1'b1;  em_more <= 1'b0;
                state    <= S_EMIT;
              end
            end
          end
        end

        S_UNL_RD: begin
          state <= S_UNL_W1;
        end

        S_UNL_W1: begin
          if (prv_rd == NULL_LINK) begin
            list_head <= nxt_rd;
          end
          state <= S_UNL_W2;
        end

        S_UNL_W2: begin
          if (free_total != '0) begin
            free_total <= free_total - LW'(1);
          end
          rem <= rem - RUN_W'(1);
          if (op_r == OP_ALLOC_CONTIG) begin
            if (rem == RUN_W'(1)) begin
              em_frame <= FRAME_W'(start);  em_status <= ST_OK;
              em_last  <= 1'b1;  em_more <= 1'b0;
              state    <= S_EMIT;
            end else begin
              cur   <= cur + FW'(1);
              state <= S_UNL_RD;
            end
          end else begin
            em_frame  <= FRAME_W'(cur);
            em_status <= ST_OK;
            em_last   <= (rem == RUN_W'(1));
            em_more   <= (rem != RUN_W'(1));
            state     <= S_EMIT;
          end
        end

        S_FR_RD: begin
          state <= S_FR_CHK;
        end

        S_FR_CHK: begin
          em_frame <= frm_r;
          em_last  <= 1'b1;
          em_more  <= 1'b0;
          if (cnt_rd == '0) begin
            em_status <= ST_ALREADY_FREE;
            state     <= S_EMIT;
          end else if (cnt_rd == REF_W'(1)) begin
            em_status <= ST_OK;
            state     <= S_FR_P1;
          end else begin
            em_status <= ST_OK;
            state     <= S_EMIT;
          end
        end

        S_FR_P1: begin
          if (list_head != NULL_LINK) begin
            state <= S_FR_P2;
          end else begin
            list_head  <= {1'b0, cur};
            free_total <= free_total + LW'(1);
            state      <= S_EMIT;
          end
        end

        S_FR_P2: begin
          list_head  <= {1'b0, cur};
          free_total <= free_total + LW'(1);
          state      <= S_EMIT;
        end

        S_EMIT: begin
          if (slot_free) begin
            out_valid <= 1'b1;
            frame_out <= em_frame;
            status    <= em_status;
            last      <= em_last;
            if (em_more) begin
              cur   <= head_idx;
              state <= S_UNL_RD;
            end else begin
              state <= S_IDLE;
            end
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ rtl/pfa_checker.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pfa_checker: port-level checks for the page frame allocator
// Watches the result channel and the reset behavior.
// ---------------------------------------------------------------------------
module pfa_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [pfa_pkg::FRAME_W-1:0]   frame_out,
  input logic [pfa_pkg::STATUS_W-1:0]  status,
  input logic                          last
);
  import pfa_pkg::*;

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(frame_out) && $stable(status)
      && $stable(last))
    else $error("stalled result changed");

  // failures always close the request
  a_fail_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_NO_FREE || status == ST_ALREADY_FREE) |-> last)
    else $error("error result not marked last");

  a_nofree_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_NO_FREE |-> frame_out == '0)
    else $error("no-free result carries a frame");

  // clearing pass follows reset, no stale result survives it
  a_reset_clear: assert property (@(posedge clk)
    rst |=> in_stall && !out_valid)
    else $error("block not blocked after reset");

endmodule

bind page_frame_allocator_unit pfa_checker u_pfa_checker (.*);
